// ----- design/bst_pkg.sv -----
// bencode tokenizer package: token kinds, error codes, parse modes, stack kinds
// no dependencies
package bst_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int SP_W = 5;

  typedef enum logic [2:0] {
    TK_INT = 3'd0, TK_HDR = 3'd1, TK_BYTE = 3'd2, TK_LIST = 3'd3,
    TK_DICT = 3'd4, TK_CLOSE = 3'd5, TK_ERR = 3'd6, TK_NONE = 3'd7
  } tok_kind_t;

  typedef enum logic [2:0] {
    ER_END = 3'd0, ER_DIGIT = 3'd1, ER_ZERO = 3'd2, ER_OVF = 3'd3,
    ER_RANGE = 3'd4, ER_DEEP = 3'd5, ER_NONE = 3'd7
  } err_code_t;

  typedef enum logic [4:0] {
    M_EXPECT = 5'b00001, M_INT_START = 5'b00010, M_INT_BODY = 5'b00100,
    M_STR_LEN = 5'b01000, M_STR_BODY = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    K_LIST = 2'd0, K_DKEY = 2'd1, K_DVAL = 2'd2, K_NONE = 2'd3
  } ckind_t;

  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [63:0] INT_POS_MAX = 64'h7fff_ffff_ffff_ffff;

endpackage

// ----- design/bencode_stream_tokenizer_core.sv -----
// bencode tokenizer top level: byte-per-cycle parser with container stack memory
// depends on bst_pkg
// output: the token of an accepted byte is registered directly into the output register
// throughput: one byte per cycle unless stalled; the top-of-stack entry is kept in a register
// so the stack memory is only written on push and read (registered) on pop; a byte
// right after a close takes the parent entry forwarded from the memory read
// stall: a waiting token holds in_tready low until out_tready takes it
// reset: synchronous active-low rst_n clears control state and sets depth_limit to 32;
// stack memory is not cleared, every entry is written on push before it is read
module bencode_stream_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // frame_start, frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [151:0] out_tdata, // token_kind, int_value, str_length, str_byte,
                                  // nest_depth, is_key, top_done, error_code, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // depth_limit
);

  // stack memory holds entries below the top; top lives in top_r
  logic [1:0] stk_mem [bst_pkg::MAX_DEPTH];
  logic [1:0] stk_rd_r;
  logic       pop_pend_r;
  logic       tog_pend_r;

  logic [5:0] lim_r;
  bst_pkg::mode_t mode_r, mode_nxt;
  logic [63:0] acc_r, acc_nxt, rem_r, rem_nxt;
  logic neg_r, neg_nxt, dig_r, dig_nxt, lz_r, lz_nxt, fin_r, fin_nxt;
  logic [5:0] dep_r, dep_nxt;
  logic [1:0] top_r, top_nxt;

  logic out_v_r;
  logic [151:0] out_d_r;

  // dictionary key/value phase flip
  function automatic logic [1:0] tog(input logic [1:0] k);
    tog = (k == bst_pkg::K_DKEY) ? bst_pkg::K_DVAL :
          (k == bst_pkg::K_DVAL) ? bst_pkg::K_DKEY : k;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  wire acc = in_tvalid && in_tready;
  wire fs = in_tuser[0];
  wire fe = in_tuser[1];
  wire [7:0] b = in_tdata;

  // effective state after optional frame restart; top forwarded from memory
  bst_pkg::mode_t m0;
  logic [63:0] a0, r0;
  logic n0, d0, z0, f0;
  logic [5:0] dp0;
  logic [1:0] t0;
  always_comb begin
    t0 = pop_pend_r ? (tog_pend_r ? tog(stk_rd_r) : stk_rd_r) : top_r;
    m0 = mode_r; a0 = acc_r; r0 = rem_r; n0 = neg_r; d0 = dig_r; z0 = lz_r;
    f0 = fin_r; dp0 = dep_r;
    if (fs) begin
      m0 = bst_pkg::M_EXPECT; a0 = '0; r0 = '0; n0 = 1'b0; d0 = 1'b0;
      z0 = 1'b0; f0 = 1'b0; dp0 = '0;
    end
  end

  // digit accumulate: acc*10 + d with overflow check
  wire is_dig = b >= bst_pkg::CH_ZERO && b <= bst_pkg::CH_NINE;
  wire [3:0] dv = 4'(b - bst_pkg::CH_ZERO);
  wire [67:0] prod = {4'd0, a0} * 68'd10 + {64'd0, dv};
  wire ovf = |prod[67:64];

  logic [2:0] kind;
  logic [2:0] ecode;
  logic [63:0] ival, slen;
  logic [7:0] sbyte;
  logic key, emit, push, pop, pushk_dict;
  logic [1:0] tk;
  logic vdone;
  logic [2:0] fkind, fcode;
  logic fdone;

  always_comb begin
    mode_nxt = m0; acc_nxt = a0; rem_nxt = r0; neg_nxt = n0; dig_nxt = d0;
    lz_nxt = z0; fin_nxt = f0; dep_nxt = dp0; top_nxt = t0;
    kind = bst_pkg::TK_NONE; ecode = bst_pkg::ER_NONE;
    ival = '0; slen = '0; sbyte = '0; key = 1'b0;
    push = 1'b0; pop = 1'b0; pushk_dict = 1'b0;
    tk = (dp0 == 6'd0) ? bst_pkg::K_NONE : t0;
    if (!f0) begin
      unique case (m0)
        bst_pkg::M_EXPECT: begin
          if (b == bst_pkg::CH_E && (tk == bst_pkg::K_LIST || tk == bst_pkg::K_DKEY)) begin
            kind = bst_pkg::TK_CLOSE; pop = 1'b1; dep_nxt = dp0 - 6'd1;
          end else if (is_dig) begin
            mode_nxt = bst_pkg::M_STR_LEN; acc_nxt = {60'd0, dv}; neg_nxt = 1'b0;
            dig_nxt = 1'b1; lz_nxt = (dv == 4'd0);
          end else if (b == bst_pkg::CH_COLON) begin
            kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_ZERO;
          end else if (tk == bst_pkg::K_DKEY) begin
            kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_DIGIT;
          end else if (b == bst_pkg::CH_I) begin
            mode_nxt = bst_pkg::M_INT_START; acc_nxt = '0; neg_nxt = 1'b0;
            dig_nxt = 1'b0; lz_nxt = 1'b0;
          end else if (b == bst_pkg::CH_L || b == bst_pkg::CH_D) begin
            if (dp0 >= lim_r) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_DEEP;
            end else begin
              push = 1'b1; pushk_dict = (b == bst_pkg::CH_D);
              dep_nxt = dp0 + 6'd1;
              top_nxt = pushk_dict ? bst_pkg::K_DKEY : bst_pkg::K_LIST;
              kind = pushk_dict ? bst_pkg::TK_DICT : bst_pkg::TK_LIST;
            end
          end else begin
            kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_DIGIT;
          end
        end
        bst_pkg::M_INT_START, bst_pkg::M_INT_BODY: begin
          mode_nxt = bst_pkg::M_INT_BODY;
          if (b == bst_pkg::CH_MINUS && m0 == bst_pkg::M_INT_START) begin
            neg_nxt = 1'b1;
          end else if (b == bst_pkg::CH_E) begin
            if (!d0) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_ZERO;
            end else if (n0 && a0 == 64'd0) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_RANGE;
            end else if (a0 > bst_pkg::INT_POS_MAX + {63'd0, n0}) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_RANGE;
            end else begin
              kind = bst_pkg::TK_INT; ival = n0 ? (~a0 + 64'd1) : a0;
            end
          end else if (is_dig) begin
            if (z0) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_ZERO;
            end else if (ovf) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_OVF;
            end else begin
              acc_nxt = prod[63:0]; lz_nxt = !d0 && dv == 4'd0; dig_nxt = 1'b1;
            end
          end else begin
            kind = bst_pkg::TK_ERR;
            ecode = z0 ? bst_pkg::ER_ZERO : bst_pkg::ER_DIGIT;
          end
        end
        bst_pkg::M_STR_LEN: begin
          if (b == bst_pkg::CH_COLON) begin
            kind = bst_pkg::TK_HDR; slen = a0; key = (tk == bst_pkg::K_DKEY);
            if (a0 != 64'd0) begin
              rem_nxt = a0; mode_nxt = bst_pkg::M_STR_BODY;
            end
          end else if (is_dig) begin
            if (z0) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_ZERO;
            end else if (ovf) begin
              kind = bst_pkg::TK_ERR; ecode = bst_pkg::ER_OVF;
            end else begin
              acc_nxt = prod[63:0]; lz_nxt = !d0 && dv == 4'd0; dig_nxt = 1'b1;
            end
          end else begin
            kind = bst_pkg::TK_ERR;
            ecode = z0 ? bst_pkg::ER_ZERO : bst_pkg::ER_DIGIT;
          end
        end
        bst_pkg::M_STR_BODY: begin
          kind = bst_pkg::TK_BYTE; sbyte = b; key = (tk == bst_pkg::K_DKEY);
          if (r0 != 64'd0) rem_nxt = r0 - 64'd1;
        end
        default: ;
      endcase
    end

    // value completion: back to expect, finish at top level
    vdone = (kind == bst_pkg::TK_CLOSE) || (kind == bst_pkg::TK_INT)
         || (kind == bst_pkg::TK_HDR && a0 == 64'd0)
         || (kind == bst_pkg::TK_BYTE && rem_nxt == 64'd0);
    fdone = 1'b0;
    fkind = kind; fcode = ecode;
    if (kind == bst_pkg::TK_ERR) fin_nxt = 1'b1;
    if (vdone) begin
      mode_nxt = bst_pkg::M_EXPECT;
      if (dep_nxt == 6'd0) begin
        fdone = 1'b1; fin_nxt = 1'b1;
      end
    end
    // premature end replaces the byte's token unless it is an error or ends the top value
    if (fe && !f0 && !fin_nxt) begin
      fkind = bst_pkg::TK_ERR; fcode = bst_pkg::ER_END; fin_nxt = 1'b1;
    end
    emit = !f0 && fkind != bst_pkg::TK_NONE;
  end

  wire is_err = fkind == bst_pkg::TK_ERR;
  // toggle of the parent for non-close completions happens on top_nxt now;
  // for close completions it is applied to the value read from memory
  wire tog_now = vdone && kind != bst_pkg::TK_CLOSE && dep_nxt != 6'd0;
  wire tog_pop = vdone && kind == bst_pkg::TK_CLOSE && dep_nxt != 6'd0;

  // stack memory: write old top on push, read entry below on pop
  always_ff @(posedge clk) begin
    if (acc && !is_err && push && dp0 != 6'd0)
      stk_mem[dp0[bst_pkg::SP_W-1:0] - 1'b1] <= t0;
    if (acc && pop && dep_nxt != 6'd0)
      stk_rd_r <= stk_mem[dep_nxt[bst_pkg::SP_W-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 6'd32; mode_r <= bst_pkg::M_EXPECT; acc_r <= '0; rem_r <= '0;
      neg_r <= 1'b0; dig_r <= 1'b0; lz_r <= 1'b0; fin_r <= 1'b0; dep_r <= '0;
      top_r <= bst_pkg::K_LIST; pop_pend_r <= 1'b0; tog_pend_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) lim_r <= (cfg_data > 6'd32) ? 6'd32 : cfg_data;
      if (acc && emit) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (acc) begin
        mode_r <= mode_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
        dig_r <= dig_nxt; lz_r <= lz_nxt; fin_r <= fin_nxt; dep_r <= dep_nxt;
        pop_pend_r <= pop && dep_nxt != 6'd0;
        tog_pend_r <= tog_pop;
      end else begin
        pop_pend_r <= 1'b0;
      end
      // top entry: new or toggled top, or the parent once its read lands
      if (acc && !pop) top_r <= tog_now ? tog(top_nxt) : top_nxt;
      else if (pop_pend_r) top_r <= t0;
      if (acc && emit) begin
        out_d_r <= {2'd0,
                    is_err ? fcode : 3'd0,
                    !is_err && fdone,
                    !is_err && key,
                    dep_nxt,
                    is_err ? 8'd0 : sbyte,
                    is_err ? 64'd0 : slen,
                    is_err ? 64'd0 : ival,
                    fkind};
      end
    end
  end

endmodule
